/* hw/rtl/abad_pkg.sv */
// shared types and constants for the astc block alpha detector
package abad_pkg;

   // configuration register indexes
   localparam logic CSR_FOOTPRINT_WIDTH  = 1'b0;
   localparam logic CSR_FOOTPRINT_HEIGHT = 1'b1;

   localparam logic [3:0] FOOTPRINT_RESET = 4'd12;

   // void-extent block mode pattern in bits 8..0
   localparam logic [8:0] VOID_EXTENT_MODE = 9'h1FC;
   localparam logic [15:0] VOID_ALPHA_OPAQUE = 16'hFFFF;

   // endpoint modes that carry an alpha channel
   localparam logic [3:0] CEM_LUM_ALPHA_DIRECT = 4'd4;
   localparam logic [3:0] CEM_LUM_ALPHA_DELTA  = 4'd5;
   localparam logic [3:0] CEM_RGB_SCALE_ALPHA  = 4'd10;
   localparam logic [3:0] CEM_RGBA_DIRECT      = 4'd12;
   localparam logic [3:0] CEM_RGBA_DELTA       = 4'd13;
   localparam logic [3:0] CEM_HDR_RGB_LDR_A    = 4'd14;
   localparam logic [3:0] CEM_HDR_RGBA         = 4'd15;

   // weight count and weight bit limits
   localparam logic [8:0] WEIGHT_COUNT_LIMIT = 9'd64;
   localparam logic [9:0] WEIGHT_BITS_LOW = 10'd24;
   localparam logic [9:0] WEIGHT_BITS_HIGH = 10'd96;
   localparam logic [7:0] BLOCK_BITS = 8'd128;

   // reciprocals for divide by 5 and by 3, scaled by 2^RECIP_SHIFT
   localparam int unsigned RECIP_SHIFT = 14;
   localparam logic [21:0] RECIP5 = 22'd3277;
   localparam logic [21:0] RECIP3 = 22'd5462;

   typedef enum logic {
      ST_IDLE,
      ST_EVAL
   } abad_state_type;

   typedef struct packed {
      logic load;    // capture request and decode block mode
      logic commit;  // write result register and sticky flag
   } abad_cmd_type;

   typedef struct packed {
      logic       legal;
      logic [3:0] width;
      logic [3:0] height;
      logic       dual_plane;
      logic       trits;
      logic       quints;
      logic [2:0] bits;
   } abad_mode_type;

endpackage

/* hw/rtl/abad_ctrl.sv */
// controller: request/result handshake sequencing for the alpha detector
module abad_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output abad_pkg::abad_cmd_type cmd
);

   abad_pkg::abad_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= abad_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         abad_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = abad_pkg::ST_EVAL;
            end
         end
         abad_pkg::ST_EVAL: begin
            // result register free or emptied this cycle
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit = 1'b1;
               state_in   = abad_pkg::ST_IDLE;
            end
         end
         default: state_in = abad_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("result not presented after commit");

   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_tready)
      else $error("new request taken while block still evaluating");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.commit))
      else $error("load and commit in same cycle");

endmodule

/* hw/rtl/abad_datapath.sv */
// datapath: block mode decode, weight limits, endpoint mode alpha test, sticky flag
module abad_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  abad_pkg::abad_cmd_type cmd,
   input  logic [127:0]           req_tdata,
   input  logic                   req_tlast,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [3:0]             csr_wdata,
   output logic                   res_alpha,
   output logic                   res_usable,
   output logic                   res_seen,
   output logic                   res_last
);

   function automatic abad_pkg::abad_mode_type decode_mode(input logic [10:0] m);
      abad_pkg::abad_mode_type d;
      logic [1:0] a;
      logic [1:0] b;
      logic       hp;
      logic [2:0] r;
      d = '0;
      d.legal = 1'b1;
      a = m[6:5];
      hp = m[9];
      d.dual_plane = m[10];
      if (m[1:0] == 2'b00) begin
         r = {m[3], m[2], m[4]};
         case (m[8:7])
            2'd0: begin
               d.width  = 4'd12;
               d.height = 4'(a) + 4'd2;
            end
            2'd1: begin
               d.width  = 4'(a) + 4'd2;
               d.height = 4'd12;
            end
            2'd2: begin
               b = m[10:9];
               d.width  = 4'(a) + 4'd6;
               d.height = 4'(b) + 4'd6;
               d.dual_plane = 1'b0;
               hp = 1'b0;
            end
            default: begin
               if (a[1]) d.legal = 1'b0;
               d.width  = a[0] ? 4'd10 : 4'd6;
               d.height = a[0] ? 4'd6 : 4'd10;
            end
         endcase
      end else begin
         r = {m[1], m[0], m[4]};
         b = m[8:7];
         case (m[3:2])
            2'd0: begin
               d.width  = 4'(b) + 4'd4;
               d.height = 4'(a) + 4'd2;
            end
            2'd1: begin
               d.width  = 4'(b) + 4'd8;
               d.height = 4'(a) + 4'd2;
            end
            2'd2: begin
               d.width  = 4'(a) + 4'd2;
               d.height = 4'(b) + 4'd8;
            end
            default: begin
               if (m[8]) begin
                  d.width  = 4'(b[0]) + 4'd2;
                  d.height = 4'(a) + 4'd2;
               end else begin
                  d.width  = 4'(a) + 4'd2;
                  d.height = 4'(b[0]) + 4'd6;
               end
            end
         endcase
      end
      if (r < 3'd2) d.legal = 1'b0;
      unique case (r)
         3'd2: begin
            d.quints = hp;
            d.bits   = 3'd1;
         end
         3'd3: begin
            d.trits = 1'b1;
            d.bits  = hp ? 3'd2 : 3'd0;
         end
         3'd4: d.bits = hp ? 3'd4 : 3'd2;
         3'd5: begin
            d.quints = 1'b1;
            d.bits   = hp ? 3'd2 : 3'd0;
         end
         3'd6: begin
            d.trits = 1'b1;
            d.bits  = hp ? 3'd3 : 3'd1;
         end
         default: d.bits = hp ? 3'd5 : 3'd3;
      endcase
      return d;
   endfunction

   function automatic logic has_alpha(input logic [3:0] cem);
      logic hit;
      case (cem) inside
         abad_pkg::CEM_LUM_ALPHA_DIRECT, abad_pkg::CEM_LUM_ALPHA_DELTA,
         abad_pkg::CEM_RGB_SCALE_ALPHA, abad_pkg::CEM_RGBA_DIRECT,
         abad_pkg::CEM_RGBA_DELTA, abad_pkg::CEM_HDR_RGB_LDR_A,
         abad_pkg::CEM_HDR_RGBA: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   // configuration registers
   logic [3:0] fp_width_ff, fp_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fp_width_ff  <= abad_pkg::FOOTPRINT_RESET;
         fp_height_ff <= abad_pkg::FOOTPRINT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            abad_pkg::CSR_FOOTPRINT_WIDTH:  fp_width_ff  <= csr_wdata;
            abad_pkg::CSR_FOOTPRINT_HEIGHT: fp_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- load stage: capture block and decode mode
   abad_pkg::abad_mode_type mode_in, mode_ff;
   logic [127:0] blk_ff;
   logic         last_ff;
   logic         void_in, void_ff;
   logic [7:0]   area;
   logic [8:0]   nweights_in, nweights_ff;

   always_comb begin
      mode_in     = decode_mode(req_tdata[10:0]);
      void_in     = (req_tdata[8:0] == abad_pkg::VOID_EXTENT_MODE);
      area        = mode_in.width * mode_in.height;
      nweights_in = mode_in.dual_plane ? {area, 1'b0} : {1'b0, area};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         blk_ff      <= req_tdata;
         last_ff     <= req_tlast;
         void_ff     <= void_in;
         mode_ff     <= mode_in;
         nweights_ff <= nweights_in;
      end
   end

   // ---------------- eval stage: weight bits, limits, endpoint modes
   logic [6:0]  n7;
   logic [9:0]  x5, x3;
   logic [21:0] prod5, prod3;
   logic [7:0]  frac;
   logic [9:0]  base, wbits;
   logic        usable, alpha;
   logic [1:0]  parts_m1;
   logic [5:0]  field;
   logic [1:0]  sel;
   logic [7:0]  pos;
   logic [127:0] shifted;
   logic [7:0]  extra;
   logic [13:0] all_bits;
   logic [13:0] mm_src;
   logic [1:0]  cls;

   always_comb begin
      n7    = nweights_ff[6:0];
      // (8n+4)/5 and (7n+2)/3 through reciprocals; n is at most 64 when used
      x5    = {n7, 3'b000} + 10'd4;
      x3    = {n7, 3'b000} - 10'(n7) + 10'd2;
      prod5 = 22'(x5) * abad_pkg::RECIP5;
      prod3 = 22'(x3) * abad_pkg::RECIP3;
      if (mode_ff.trits) frac = prod5[abad_pkg::RECIP_SHIFT +: 8];
      else if (mode_ff.quints) frac = prod3[abad_pkg::RECIP_SHIFT +: 8];
      else frac = 8'd0;
      base  = 10'(mode_ff.bits) * 10'(n7);
      wbits = base + 10'(frac);

      usable = void_ff ||
               (mode_ff.legal && (nweights_ff <= abad_pkg::WEIGHT_COUNT_LIMIT) &&
                (wbits >= abad_pkg::WEIGHT_BITS_LOW) &&
                (wbits <= abad_pkg::WEIGHT_BITS_HIGH) &&
                (mode_ff.width <= fp_width_ff) && (mode_ff.height <= fp_height_ff));

      parts_m1 = blk_ff[12:11];
      field    = blk_ff[28:23];
      sel      = field[1:0];

      // extra mode bits sit just below the weight area
      case (parts_m1)
         2'd1:    pos = abad_pkg::BLOCK_BITS - wbits[7:0] - 8'd2;
         2'd2:    pos = abad_pkg::BLOCK_BITS - wbits[7:0] - 8'd5;
         default: pos = abad_pkg::BLOCK_BITS - wbits[7:0] - 8'd8;
      endcase
      shifted = blk_ff >> pos[6:0];
      case (parts_m1)
         2'd1:    extra = {6'd0, shifted[1:0]};
         2'd2:    extra = {3'd0, shifted[4:0]};
         default: extra = shifted[7:0];
      endcase
      all_bits = {extra, field};

      alpha = 1'b0;
      if (void_ff) begin
         alpha = (blk_ff[127:112] != abad_pkg::VOID_ALPHA_OPAQUE);
      end else if (usable) begin
         if (parts_m1 == 2'd0) begin
            alpha = has_alpha(blk_ff[16:13]);
         end else if (sel == 2'd0) begin
            alpha = has_alpha(field[5:2]);
         end else begin
            for (int i = 0; i < 4; i++) begin
               mm_src = all_bits >> (4'd3 + 4'(parts_m1) + 4'(2 * i));
               cls    = {1'b0, all_bits[2 + i]} + sel - 2'd1;
               if ((i <= int'(parts_m1)) && has_alpha({cls, mm_src[1:0]}))
                  alpha = 1'b1;
            end
         end
      end
   end

   // ---------------- result register and sticky flag
   logic alpha_sticky_ff, alpha_sticky_in;
   logic seen_in;

   assign seen_in         = alpha_sticky_ff | alpha;
   assign alpha_sticky_in = last_ff ? 1'b0 : seen_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_sticky_ff <= 1'b0;
      end else if (cmd.commit) begin
         alpha_sticky_ff <= alpha_sticky_in;
      end
   end

   logic res_alpha_ff, res_usable_ff, res_seen_ff, res_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         res_alpha_ff  <= alpha;
         res_usable_ff <= usable;
         res_seen_ff   <= seen_in;
         res_last_ff   <= last_ff;
      end
   end

   assign res_alpha  = res_alpha_ff;
   assign res_usable = res_usable_ff;
   assign res_seen   = res_seen_ff;
   assign res_last   = res_last_ff;

   a_sticky_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && last_ff) |=> !alpha_sticky_ff)
      else $error("sticky flag not cleared after last block");

   a_sticky_holds: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !last_ff && alpha) |=> (alpha_sticky_ff && res_seen_ff))
      else $error("alpha not recorded in sticky flag");

   a_alpha_usable: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (!res_alpha_ff || res_usable_ff))
      else $error("alpha reported for unusable block");

endmodule

/* hw/rtl/astc_block_alpha_detector.sv */
// top level of the astc block alpha detector
// a request is captured when it is taken, and its result is registered when the controller commits it
// no new request is taken while one is evaluated, and evaluation waits until the result register is free
// a new request is taken while the previous result still waits on the rsp side
// reset (synchronous, active high) clears the sticky alpha flag and the handshake state,
// and sets both footprint registers to 12
module astc_block_alpha_detector (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // block_low[63:0], block_high[127:64]
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // block_alpha[0], block_usable[1], alpha_seen[2], zero
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [3:0]   csr_wdata
);

   abad_pkg::abad_cmd_type cmd;
   logic res_alpha, res_usable, res_seen;

   abad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   abad_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .res_alpha  (res_alpha),
      .res_usable (res_usable),
      .res_seen   (res_seen),
      .res_last   (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, res_seen, res_usable, res_alpha};

endmodule

/* sim/abad_result_checker.sv */
// checker for the astc block alpha detector: predicts each result and compares it on the rsp side
`timescale 1ns / 100ps

module abad_result_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [127:0] req_tdata,   // block_low[63:0], block_high[127:64]
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [7:0]   rsp_tdata,   // block_alpha[0], block_usable[1], alpha_seen[2], zero
   input  logic         rsp_tlast,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [3:0]   csr_wdata,
   output int unsigned  fail_count,
   output int unsigned  pending_count
);

   typedef struct packed {
      logic block_alpha;
      logic block_usable;
      logic alpha_seen;
      logic last_out;
   } alpha_result_type;

   alpha_result_type alpha_results_due[$];
   logic [3:0]       width_limit;
   logic [3:0]       height_limit;
   logic             sticky_alpha;

   function automatic logic endpoint_has_alpha(input logic [3:0] cem);
      case (cem) inside
         abad_pkg::CEM_LUM_ALPHA_DIRECT, abad_pkg::CEM_LUM_ALPHA_DELTA,
         abad_pkg::CEM_RGB_SCALE_ALPHA, abad_pkg::CEM_RGBA_DIRECT,
         abad_pkg::CEM_RGBA_DELTA, abad_pkg::CEM_HDR_RGB_LDR_A,
         abad_pkg::CEM_HDR_RGBA: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // footprint and weight bits of a non-void block mode, planes included; returns legality
   function automatic logic decode_block_mode(input logic [10:0] m, output int unsigned w,
                                              output int unsigned h, output int unsigned nbits);
      int unsigned a;
      int unsigned hp;
      int unsigned dp;
      int unsigned r;
      int unsigned bt;
      int unsigned n;
      logic        tr;
      logic        qu;
      a = m[6:5];
      hp = m[9];
      dp = m[10];
      tr = 1'b0;
      qu = 1'b0;
      bt = 0;
      w = 0;
      h = 0;
      nbits = 0;
      if (m[1:0] == 2'b00) begin
         r = {m[3], m[2], m[4]};
         case (m[8:7])
            2'd0: begin
               w = 12;
               h = a + 2;
            end
            2'd1: begin
               w = a + 2;
               h = 12;
            end
            2'd2: begin
               // wide layout reuses the plane and precision bits as height
               w = a + 6;
               h = m[10:9] + 6;
               dp = 0;
               hp = 0;
            end
            default: begin
               if (a >= 2) return 1'b0;
               w = (a != 0) ? 10 : 6;
               h = (a != 0) ? 6 : 10;
            end
         endcase
      end else begin
         r = {m[1], m[0], m[4]};
         case (m[3:2])
            2'd0: begin
               w = m[8:7] + 4;
               h = a + 2;
            end
            2'd1: begin
               w = m[8:7] + 8;
               h = a + 2;
            end
            2'd2: begin
               w = a + 2;
               h = m[8:7] + 8;
            end
            default: begin
               if (m[8]) begin
                  w = m[7] + 2;
                  h = a + 2;
               end else begin
                  w = a + 2;
                  h = m[7] + 6;
               end
            end
         endcase
      end
      if (r < 2) return 1'b0;
      case (r)
         2: begin
            bt = 1;
            qu = (hp != 0);
         end
         3: begin
            tr = 1'b1;
            bt = hp ? 2 : 0;
         end
         4: bt = hp ? 4 : 2;
         5: begin
            qu = 1'b1;
            bt = hp ? 2 : 0;
         end
         6: begin
            tr = 1'b1;
            bt = hp ? 3 : 1;
         end
         default: bt = hp ? 5 : 3;
      endcase
      n = w * h * (dp + 1);
      if (tr) nbits = ((8 + bt * 5) * n + 4) / 5;
      else if (qu) nbits = ((7 + bt * 3) * n + 2) / 3;
      else nbits = bt * n;
      return (n <= abad_pkg::WEIGHT_COUNT_LIMIT && nbits >= abad_pkg::WEIGHT_BITS_LOW &&
              nbits <= abad_pkg::WEIGHT_BITS_HIGH);
   endfunction

   function automatic alpha_result_type predict_block_alpha(input logic [127:0] blk,
                                                            input logic last);
      alpha_result_type res;
      int unsigned      w;
      int unsigned      h;
      int unsigned      nbits;
      int unsigned      parts;
      int unsigned      mbits;
      int unsigned      pos;
      int unsigned      extra;
      logic [127:0]     shifted;
      logic [5:0]       field;
      logic [13:0]      cem_bits;
      logic [1:0]       cls;
      logic [3:0]       cem;
      res = '0;
      if (blk[8:0] == abad_pkg::VOID_EXTENT_MODE) begin
         res.block_usable = 1'b1;
         res.block_alpha = (blk[127:112] < abad_pkg::VOID_ALPHA_OPAQUE);
      end else if (decode_block_mode(blk[10:0], w, h, nbits) &&
                   w <= width_limit && h <= height_limit) begin
         res.block_usable = 1'b1;
         parts = blk[12:11] + 1;
         field = blk[28:23];
         if (parts == 1) begin
            res.block_alpha = endpoint_has_alpha(blk[16:13]);
         end else if (field[1:0] == 2'b00) begin
            // same class everywhere: one shared mode
            res.block_alpha = endpoint_has_alpha(field[5:2]);
         end else begin
            // extra mode bits sit right below the weight bits
            mbits = 3 * parts - 4;
            pos = abad_pkg::BLOCK_BITS - nbits - mbits;
            shifted = blk >> pos;
            extra = shifted[7:0] & ((1 << mbits) - 1);
            cem_bits = {extra[7:0], field};
            for (int i = 0; i < parts; i++) begin
               cls = 2'(cem_bits[2 + i] + field[1:0] - 1);
               cem = {cls, cem_bits[2 + parts + 2 * i +: 2]};
               if (endpoint_has_alpha(cem)) res.block_alpha = 1'b1;
            end
         end
      end
      res.alpha_seen = sticky_alpha | res.block_alpha;
      res.last_out = last;
      return res;
   endfunction

   task automatic check_field(input string name, input logic want, input logic got);
      if (want !== got) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      alpha_result_type want;
      alpha_result_type got;
      if (reset) begin
         alpha_results_due.delete();
         width_limit = abad_pkg::FOOTPRINT_RESET;
         height_limit = abad_pkg::FOOTPRINT_RESET;
         sticky_alpha = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[0], rsp_tdata[1], rsp_tdata[2], rsp_tlast};
            if (alpha_results_due.size() == 0) begin
               $error("result with no request outstanding");
               fail_count++;
            end else begin
               want = alpha_results_due.pop_front();
               check_field("block_alpha", want.block_alpha, got.block_alpha);
               check_field("block_usable", want.block_usable, got.block_usable);
               check_field("alpha_seen", want.alpha_seen, got.alpha_seen);
               check_field("last_out", want.last_out, got.last_out);
            end
         end
         if (req_tvalid && req_tready) begin
            want = predict_block_alpha(req_tdata, req_tlast);
            alpha_results_due.push_back(want);
            sticky_alpha = want.last_out ? 1'b0 : want.alpha_seen;
         end
         if (csr_we) begin
            case (csr_index)
               abad_pkg::CSR_FOOTPRINT_WIDTH: width_limit = csr_wdata;
               abad_pkg::CSR_FOOTPRINT_HEIGHT: height_limit = csr_wdata;
               default: ;
            endcase
         end
      end
      // nonblocking so the stimulus side never sees a count from the middle of an edge
      pending_count <= alpha_results_due.size();
   end

endmodule

/* sim/tb_astc_block_alpha_detector.sv */
// testbench top for the astc block alpha detector: stimulus, handshake pacing and verdict
`timescale 1ns / 100ps

module tb_astc_block_alpha_detector;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned PHASE_ITEMS = 250;
   localparam int unsigned NUM_PHASES = 7;

   // endpoint modes without alpha
   localparam logic [3:0] CEM_HDR_LUM_SMALL = 4'd3;
   localparam logic [3:0] CEM_RGB_DIRECT = 4'd8;

   // block modes used by the directed requests
   localparam logic [10:0] MODE_4X3_QUINT = 11'h032;
   localparam logic [10:0] MODE_7X5_QUINT = 11'h1F2;
   localparam logic [10:0] MODE_7X5_DUAL = 11'h5F2;
   localparam logic [10:0] MODE_2X8_QUINT = 11'h01A;
   localparam logic [10:0] MODE_RESERVED = 11'h1C0;
   localparam logic [10:0] MODE_FEW_BITS = 11'h001;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [7:0]   rsp_tdata;
   logic         rsp_tlast;
   logic         csr_we;
   logic         csr_index;
   logic [3:0]   csr_wdata;
   int unsigned  fail_count;
   int unsigned  pending_count;
   int unsigned  cycle_count;
   bit           idle_enabled;

   astc_block_alpha_detector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   abad_result_checker u_result_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // low half first so the first rising edge comes after reset is driven
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_astc_block_alpha_detector NOT OK");
         $finish;
      end
   end

   // rsp side: random stall before each result, none while idling is off
   initial begin : rsp_side
      int unsigned stall;
      forever begin
         stall = idle_enabled ? $urandom_range(0, 15) : 0;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
      end
   end

   task automatic send_block(input logic [63:0] lo, input logic [63:0] hi, input logic last);
      int unsigned gap;
      gap = idle_enabled ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {hi, lo};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_footprint(input logic [3:0] w, input logic [3:0] h);
      csr_we <= 1'b1;
      csr_index <= abad_pkg::CSR_FOOTPRINT_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= abad_pkg::CSR_FOOTPRINT_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      logic [63:0] lo;
      logic [63:0] hi;
      logic [3:0]  fw [NUM_PHASES];
      logic [3:0]  fh [NUM_PHASES];
      int unsigned kind;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= abad_pkg::CSR_FOOTPRINT_WIDTH;
      csr_wdata <= '0;
      idle_enabled = 1'b1;
      fw = '{4'd12, 4'd4, 4'd15, 4'd0, 4'd8, 4'd0, 4'd0};
      fh = '{4'd12, 4'd4, 4'd15, 4'd9, 4'd4, 4'd0, 4'd0};
      fw[5] = 4'($urandom_range(4, 12));
      fh[5] = 4'($urandom_range(4, 12));
      fw[6] = 4'($urandom_range(4, 12));
      fh[6] = 4'($urandom_range(4, 12));
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed requests under the reset footprint
      send_block(64'h0, 64'h0, 1'b0);
      send_block('1, '1, 1'b1);
      send_block(64'(abad_pkg::VOID_EXTENT_MODE), {abad_pkg::VOID_ALPHA_OPAQUE, 48'h0}, 1'b0);
      send_block(64'(abad_pkg::VOID_EXTENT_MODE), {16'hFFFE, 48'h0}, 1'b1);
      send_block(64'(abad_pkg::VOID_EXTENT_MODE) | 64'h600, 64'h0000_FFFF_FFFF_FFFF, 1'b0);
      send_block(64'(MODE_RESERVED), 64'h0, 1'b0);
      send_block(64'(MODE_FEW_BITS), 64'h0, 1'b0);
      send_block(64'(MODE_7X5_DUAL) | (64'(abad_pkg::CEM_RGBA_DIRECT) << 13), 64'h0, 1'b1);
      send_block(64'(MODE_4X3_QUINT) | (64'(abad_pkg::CEM_LUM_ALPHA_DIRECT) << 13),
                 64'h0, 1'b0);
      send_block(64'(MODE_4X3_QUINT) | (64'(abad_pkg::CEM_HDR_RGBA) << 13), 64'h0, 1'b0);
      send_block(64'(MODE_4X3_QUINT) | (64'(CEM_RGB_DIRECT) << 13), 64'h0, 1'b1);
      send_block(64'(MODE_4X3_QUINT) | (64'd1 << 11) |
                 (64'(abad_pkg::CEM_RGBA_DELTA) << 25), 64'h0, 1'b0);
      send_block(64'(MODE_4X3_QUINT) | (64'd1 << 11) | (64'(CEM_HDR_LUM_SMALL) << 25),
                 64'h0, 1'b1);
      // class selector set: per-partition modes with random content
      lo = {$urandom, $urandom};
      lo[12:0] = {2'd3, MODE_4X3_QUINT};
      lo[24:23] = 2'd3;
      send_block(lo, {$urandom, $urandom}, 1'b0);
      lo = {$urandom, $urandom};
      lo[12:0] = {2'd2, MODE_7X5_QUINT};
      lo[24:23] = 2'd1;
      send_block(lo, {$urandom, $urandom}, 1'b0);
      lo = {$urandom, $urandom};
      lo[12:0] = {2'd1, MODE_2X8_QUINT};
      lo[24:23] = 2'd2;
      send_block(lo, {$urandom, $urandom}, 1'b1);
      wait_idle();

      // footprint smaller than some of the decoded sizes
      write_footprint(4'd6, 4'd5);
      send_block(64'(MODE_7X5_QUINT) | (64'(abad_pkg::CEM_RGBA_DIRECT) << 13), 64'h0, 1'b0);
      send_block(64'(MODE_4X3_QUINT) | (64'(abad_pkg::CEM_RGBA_DELTA) << 13), 64'h0, 1'b0);
      send_block(64'(MODE_2X8_QUINT) | (64'(abad_pkg::CEM_HDR_RGB_LDR_A) << 13),
                 64'h0, 1'b1);
      wait_idle();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         write_footprint(fw[phase], fh[phase]);
         idle_enabled = (phase % 3) != 2;
         for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            kind = $urandom_range(0, 99);
            if (kind < 12) begin
               lo[8:0] = abad_pkg::VOID_EXTENT_MODE;
               if ($urandom_range(0, 2) == 0) hi[63:48] = abad_pkg::VOID_ALPHA_OPAQUE;
            end else if (kind < 80) begin
               // low bits nonzero keep the precision field legal; small footprints are common
               lo[1:0] = 2'($urandom_range(1, 3));
               if ($urandom_range(0, 2) != 0) lo[3:2] = 2'd0;
               lo[10] = ($urandom_range(0, 3) == 0);
               if ($urandom_range(0, 3) != 0) lo[24:23] = 2'($urandom_range(1, 3));
            end else if (kind < 88) begin
               lo[1:0] = 2'b00;
               lo[8:7] = 2'($urandom_range(0, 3));
            end
            send_block(lo, hi, $urandom_range(0, 7) == 0);
         end
         wait_idle();
      end

      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_astc_block_alpha_detector OK");
      end else begin
         $display("tb_astc_block_alpha_detector NOT OK");
      end
      $finish;
   end

endmodule

/* astc_block_alpha_detector.f */
hw/rtl/abad_pkg.sv
hw/rtl/abad_ctrl.sv
hw/rtl/abad_datapath.sv
hw/rtl/astc_block_alpha_detector.sv
sim/abad_result_checker.sv
sim/tb_astc_block_alpha_detector.sv
